### src/delta_r_veto_overlap_filter_top_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro expects clk and arst_n in scope.
`ifndef DELTA_R_VETO_OVERLAP_FILTER_TOP_ASSERT_SVH
`define DELTA_R_VETO_OVERLAP_FILTER_TOP_ASSERT_SVH

// Same-cycle implication
`define DVOF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dvof assertion failed");

// Next-cycle implication
`define DVOF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dvof assertion failed");

`endif

### src/dvof_pkg.sv
// ----------------------------------------------------------------------------
// dvof_pkg
// Types and constants of the delta-R veto overlap filter.
// ----------------------------------------------------------------------------
package dvof_pkg;

	// input word kinds, carried on tuser
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_TEST  = 2'd2
	} op_t;

	// configuration register indexes
	localparam logic REG_DR_CUT_SQ  = 1'b0;
	localparam logic REG_MIN_PASS   = 1'b1;

	localparam int CUT_W            = 27;
	localparam int CNT_W            = 7;
	localparam logic [CUT_W-1:0] DR_CUT_SQ_RST = 27'd167772;
	localparam logic [CNT_W-1:0] MIN_PASS_RST  = 7'd1;
	localparam logic [CNT_W-1:0] KEPT_MAX      = 7'd64;

	// phi in 2^-10 rad: full and half turn
	localparam int PHI_TURN         = 6434;
	localparam int PHI_HALF_TURN    = 3217;
	// 0.01^2 in 2^-20 units, rounded up
	localparam int SMALL_DR_SQ      = 105;

	// one veto particle or candidate
	typedef struct packed {
		logic signed [13:0] eta;
		logic signed [12:0] phi;
		logic        [15:0] pt;
	} entry_t;

	// control travelling with the compare pipe
	typedef struct packed {
		logic vld;	// entry is a stored veto entry
		logic fin;	// final step of the ring pass
	} cmp_ctl_t;

	typedef struct packed {
		logic close;	// entry vetoes the candidate
		logic fin;
	} cmp_res_t;

endpackage

### src/dvof_cell.sv
// ----------------------------------------------------------------------------
// dvof_cell
// One place of the veto ring: holds one entry, takes its neighbour's entry
// (or a fresh one when injecting) on each shift.
// ----------------------------------------------------------------------------
module dvof_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            inject,
	input  dvof_pkg::entry_t nbr,
	input  dvof_pkg::entry_t ext,
	output dvof_pkg::entry_t q
);

	dvof_pkg::entry_t ent_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= inject ? ext : nbr;
		end
	end

	assign q = ent_q;

endmodule

### src/dvof_cmp.sv
// ----------------------------------------------------------------------------
// dvof_cmp
// Three-stage compare of the candidate with one veto entry per cycle:
// differences and phi wrap, squares and pt test, sum and cuts.
// ----------------------------------------------------------------------------
module dvof_cmp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dvof_pkg::entry_t              cand,
	input  dvof_pkg::entry_t              ent,
	input  dvof_pkg::cmp_ctl_t            ctl,
	input  logic [dvof_pkg::CUT_W-1:0]    dr_cut_sq,
	output dvof_pkg::cmp_res_t            res
);

	logic signed [13:0] dp_raw;
	logic signed [12:0] dp_wrap;
	logic signed [14:0] de_s1;
	logic signed [12:0] dp_s1;
	logic signed [16:0] pd_s1;
	logic        [15:0] vpt_s1;
	dvof_pkg::cmp_ctl_t ctl_s1;

	logic signed [29:0] de_sq;
	logic signed [25:0] dp_sq;
	logic signed [23:0] pd_x100;
	logic        [27:0] de2_s2;
	logic        [23:0] dp2_s2;
	logic               ptok_s2;
	dvof_pkg::cmp_ctl_t ctl_s2;

	logic        [28:0] d2;
	dvof_pkg::cmp_res_t res_s3;

	// phi difference wrapped once into +-half turn
	always_comb begin
		dp_raw = 14'(cand.phi) - 14'(ent.phi);
		dp_wrap = 13'(dp_raw);
		if (dp_raw > $signed(14'(dvof_pkg::PHI_HALF_TURN))) begin
			dp_wrap = 13'(dp_raw - $signed(14'(dvof_pkg::PHI_TURN)));
		end else if (dp_raw < -$signed(14'(dvof_pkg::PHI_HALF_TURN))) begin
			dp_wrap = 13'(dp_raw + $signed(14'(dvof_pkg::PHI_TURN)));
		end
	end

	// stage 1: differences
	always_ff @(posedge clk) begin
		de_s1  <= 15'(cand.eta) - 15'(ent.eta);
		dp_s1  <= dp_wrap;
		pd_s1  <= $signed({1'b0, cand.pt}) - $signed({1'b0, ent.pt});
		vpt_s1 <= ent.pt;
	end

	// stage 2: squares, relative pt excess below veto pt
	assign de_sq   = de_s1 * de_s1;
	assign dp_sq   = dp_s1 * dp_s1;
	assign pd_x100 = (24'(pd_s1) <<< 6) + (24'(pd_s1) <<< 5) + (24'(pd_s1) <<< 2);

	always_ff @(posedge clk) begin
		de2_s2  <= de_sq[27:0];
		dp2_s2  <= dp_sq[23:0];
		ptok_s2 <= pd_x100 < $signed({8'd0, vpt_s1});
	end

	// stage 3: squared distance against both cuts
	assign d2 = {1'b0, de2_s2} + {5'd0, dp2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			res_s3 <= '0;
		end else begin
			ctl_s1       <= ctl;
			ctl_s2       <= ctl_s1;
			res_s3.fin   <= ctl_s2.fin;
			res_s3.close <= ctl_s2.vld &&
				((d2 < 29'(dvof_pkg::SMALL_DR_SQ) && ptok_s2) || d2 < {2'b0, dr_cut_sq});
		end
	end

	assign res = res_s3;

endmodule

### src/delta_r_veto_overlap_filter_top.sv
// Sequence: a test word passes the states RUN, DRAIN and OUT and gives one
// result; clear and load words give no result. No new word is taken until
// a test word's result is registered; the test makes one full turn of the
// veto ring through the single compare pipe (one entry per cycle).
// Reset: asynchronous, clears the table count, kept count and all control;
// config registers return to dr_cut_sq 167772 and min_pass_count 1.
// ----------------------------------------------------------------------------
// delta_r_veto_overlap_filter_top
// Per-event overlap removal: veto entries sit in a ring of cells that turns
// once per candidate, feeding a pipelined dR compare.
// ----------------------------------------------------------------------------
module delta_r_veto_overlap_filter_top #(
	parameter int MAX_VETO = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [26:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,	// eta[13:0], phi[26:14], pt[42:27], zero fill
	input  logic [1:0]  s_tuser,	// op
	input  logic        s_tlast,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,	// keep[0], kept_count[7:1], event_pass[8], zero fill
	output logic        m_tlast
);

	localparam int IW = (MAX_VETO > 1) ? $clog2(MAX_VETO) : 1;
	localparam int CW = $clog2(MAX_VETO + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [IW-1:0]                  step_q;
	logic [CW-1:0]                  count_q;
	logic [dvof_pkg::CNT_W-1:0]     kept_q;
	logic [dvof_pkg::CUT_W-1:0]     cut_q;
	logic [dvof_pkg::CNT_W-1:0]     min_pass_q;
	logic                           hit_q;
	logic                           keep_q;
	dvof_pkg::entry_t               cand_q;
	logic                           last_q;

	logic                           m_tvalid_q;
	logic                           keep_out_q;
	logic [dvof_pkg::CNT_W-1:0]     kept_out_q;
	logic                           pass_out_q;
	logic                           last_out_q;

	dvof_pkg::entry_t               in_ent;
	dvof_pkg::op_t                  op;
	logic                           in_acc;
	logic                           do_load;
	logic                           shift;
	logic                           last_step;
	logic                           emit;
	logic [dvof_pkg::CNT_W-1:0]     kept_n;
	dvof_pkg::cmp_ctl_t             ctl;
	dvof_pkg::cmp_res_t             res;
	dvof_pkg::entry_t               cell_w [MAX_VETO];

	// input word unpacking
	assign in_ent.eta = $signed(s_tdata[13:0]);
	assign in_ent.phi = $signed(s_tdata[26:14]);
	assign in_ent.pt  = s_tdata[42:27];
	assign op         = dvof_pkg::op_t'(s_tuser);

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign do_load   = in_acc && op == dvof_pkg::OP_LOAD && count_q != CW'(MAX_VETO);
	assign last_step = step_q == IW'(MAX_VETO - 1);
	assign shift     = do_load || state_q == ST_RUN;
	assign emit      = state_q == ST_OUT && (!m_tvalid_q || m_tready);

	// veto ring: loads enter at the tail, a test turns it once round
	for (genvar i = 0; i < MAX_VETO; i++) begin : g_cell
		dvof_cell u_cell (
			.clk    (clk),
			.shift  (shift),
			.inject (do_load && i == MAX_VETO - 1),
			.nbr    (cell_w[(i + 1) % MAX_VETO]),
			.ext    (in_ent),
			.q      (cell_w[i])
		);
	end

	// stored entries occupy the top count_q cells
	assign ctl.vld = state_q == ST_RUN &&
		((CW + 1)'(step_q) + (CW + 1)'(count_q)) >= (CW + 1)'(MAX_VETO);
	assign ctl.fin = state_q == ST_RUN && last_step;

	dvof_cmp u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand      (cand_q),
		.ent       (cell_w[0]),
		.ctl       (ctl),
		.dr_cut_sq (cut_q),
		.res       (res)
	);

	// saturating kept count including this candidate
	assign kept_n = (keep_q && kept_q < dvof_pkg::KEPT_MAX) ?
		kept_q + dvof_pkg::CNT_W'(1) : kept_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q      <= dvof_pkg::DR_CUT_SQ_RST;
			min_pass_q <= dvof_pkg::MIN_PASS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				dvof_pkg::REG_DR_CUT_SQ: begin
					cut_q <= cfg_wdata;
				end
				dvof_pkg::REG_MIN_PASS: begin
					min_pass_q <= cfg_wdata[dvof_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// candidate hold
	always_ff @(posedge clk) begin
		if (in_acc && op == dvof_pkg::OP_TEST) begin
			cand_q <= in_ent;
			last_q <= s_tlast;
		end
	end

	// sequencer, table count and kept count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			count_q <= '0;
			kept_q  <= '0;
			hit_q   <= 1'b0;
			keep_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (op)
							dvof_pkg::OP_CLEAR: begin
								count_q <= '0;
								kept_q  <= '0;
							end
							dvof_pkg::OP_LOAD: begin
								if (do_load) begin
									count_q <= count_q + CW'(1);
								end
							end
							dvof_pkg::OP_TEST: begin
								step_q  <= '0;
								hit_q   <= 1'b0;
								state_q <= ST_RUN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					hit_q  <= hit_q | res.close;
					step_q <= step_q + IW'(1);
					if (last_step) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					hit_q <= hit_q | res.close;
					if (res.fin) begin
						keep_q  <= !(hit_q || res.close);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (emit) begin
						kept_q  <= last_q ? '0 : kept_n;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			keep_out_q <= keep_q;
			kept_out_q <= kept_n;
			pass_out_q <= last_q && kept_n >= min_pass_q;
			last_out_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, pass_out_q, kept_out_q, keep_out_q};
	assign m_tlast  = last_out_q;

endmodule

### src/dvof_checker.sv
// ----------------------------------------------------------------------------
// dvof_checker
// Port-level checks of the overlap filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "delta_r_veto_overlap_filter_top_assert.svh"

module dvof_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result word holds
	`DVOF_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tlast, m_tdata}))

	// a test word occupies the block: input closes straight after it
	`DVOF_ASSERT_NXT(a_test_busy, s_tvalid && s_tready && s_tuser == dvof_pkg::OP_TEST, !s_tready)

	// zero fill above the result fields
	`DVOF_ASSERT_IMP(a_out_fill, m_tvalid, m_tdata[15:9] == 7'd0)

	// event pass only on the last result of an event
	`DVOF_ASSERT_IMP(a_pass_last, m_tvalid && m_tdata[8], m_tlast)

endmodule

bind delta_r_veto_overlap_filter_top dvof_checker u_dvof_checker (.*);
